// ===== hdl/dbts_pkg.sv =====
// Shared types and constants for the deauth burst threat scorer.
package dbts_pkg;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_COUNTED  = 2'd0,
        ST_FILTERED = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOFRAME  = 2'd3
    } fstatus_t;

    typedef enum logic [1:0] {
        LV_STARTUP = 2'd0,
        LV_NORMAL  = 2'd1,
        LV_CAUTION = 2'd2,
        LV_ALERT   = 2'd3
    } level_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_FSEARCH,
        CS_FALLOC,
        CS_FREAD,
        CS_FWAIT,
        CS_FWRITE,
        CS_TWALK,
        CS_TLAST,
        CS_TFINISH,
        CS_DONE
    } cstate_t;

    localparam logic [2:0] REG_WINDOW    = 3'd0;
    localparam logic [2:0] REG_CAUT_CNT  = 3'd1;
    localparam logic [2:0] REG_ALERT_CNT = 3'd2;
    localparam logic [2:0] REG_BCAST_CNT = 3'd3;
    localparam logic [2:0] REG_CEILING   = 3'd4;
    localparam logic [2:0] REG_CAUT_SC   = 3'd5;
    localparam logic [2:0] REG_ALERT_SC  = 3'd6;
    localparam logic [2:0] REG_DECAY     = 3'd7;

    localparam logic signed [7:0] SIGNAL_FLOOR = -8'sd95;
    localparam logic [3:0] SUB_DISASSOC = 4'd10;
    localparam logic [3:0] SUB_DEAUTH   = 4'd12;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture the item
        logic scan_clr;   // zero the slot index
        logic scan_inc;   // advance the slot index
        logic hit_take;   // record a match at the current index
        logic free_take;  // record a free slot at the current index
        logic alloc;      // write a new entry at the free slot
        logic rd_hit;     // read the selected slot from the RAM
        logic wr_hit;     // write the updated counts back
        logic tick_acc;   // score the slot whose data is out of the RAM
        logic tick_fin;   // apply decay and set the level
        logic finish;     // drive the result strobe
    } dbts_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic     filtered;
        logic     scan_last;
        logic     cur_match;
        logic     cur_free;
        logic     have_hit;
        logic     have_free;
        opcode_t  op;
    } dbts_stat_t;

endpackage

// ===== hdl/deauth_burst_threat_scorer_top.sv =====
// Top level of the deauth burst threat scorer.
//
// Command port: present an item on the input ports with start high; it is
// taken at a rising edge where start is high and busy is low. opcode 0 is a
// received frame header, 1 an analysis tick, 2 a score clear.
// Each item produces exactly one result: score, level, frame_status and
// points_raised are valid for one cycle while done is high. The receiver
// cannot stall; the result is simply presented once.
// Sequencing: a filtered frame, clear or unused opcode finishes once the
// registered opcode is seen. A frame walks the source table one slot a cycle
// until it matches or reaches the last slot, then reads, updates and writes
// back that slot; when the table is full it finishes without the read. A tick
// walks every slot through the table RAM read port, then applies decay and
// sets the level.
// One item is handled at a time; busy drops in the cycle done is high, so the
// next transfer can be taken at the edge that takes the result.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge;
// write only while the block is idle.
// Reset (rst_n low, asynchronous) clears slot valid bits, the score, the
// decay timestamp and the level, and restores register defaults. Table
// contents are not cleared; stale data is ignored through the valid bits and the new-entry flag.
module deauth_burst_threat_scorer_top #(
    parameter int SOURCE_SLOTS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [1:0]        opcode,
    input  logic [31:0]       time_ms,
    input  logic [47:0]       source_mac,
    input  logic [47:0]       dest_mac,
    input  logic [7:0]        frame_control_low,
    input  logic signed [7:0] signal_dbm,
    input  logic              analysis_enabled,
    output logic [4:0]        score,
    output logic [1:0]        level,
    output logic [1:0]        frame_status,
    output logic [7:0]        points_raised
);
    import dbts_pkg::*;

    logic [31:0] window_reg, decay_reg;
    logic [15:0] caut_cnt_reg, alert_cnt_reg, bcast_cnt_reg;
    logic [4:0]  ceil_reg, caut_sc_reg, alert_sc_reg;

    // register file; three index bits cover exactly the eight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= 32'd5000;
            caut_cnt_reg  <= 16'd8;
            alert_cnt_reg <= 16'd20;
            bcast_cnt_reg <= 16'd5;
            ceil_reg      <= 5'd20;
            caut_sc_reg   <= 5'd3;
            alert_sc_reg  <= 5'd6;
            decay_reg     <= 32'd60000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW:    window_reg    <= cfg_data;
                REG_CAUT_CNT:  caut_cnt_reg  <= cfg_data[15:0];
                REG_ALERT_CNT: alert_cnt_reg <= cfg_data[15:0];
                REG_BCAST_CNT: bcast_cnt_reg <= cfg_data[15:0];
                REG_CEILING:   ceil_reg      <= cfg_data[4:0];
                REG_CAUT_SC:   caut_sc_reg   <= cfg_data[4:0];
                REG_ALERT_SC:  alert_sc_reg  <= cfg_data[4:0];
                REG_DECAY:     decay_reg     <= cfg_data;
                default:       window_reg    <= window_reg;
            endcase
        end
    end

    dbts_cmd_t  cmd;
    dbts_stat_t stat;

    dbts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dbts_dp #(.SOURCE_SLOTS(SOURCE_SLOTS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .stat                  (stat),
        .opcode                (opcode),
        .time_ms               (time_ms),
        .source_mac            (source_mac),
        .dest_mac              (dest_mac),
        .frame_control_low     (frame_control_low),
        .signal_dbm            (signal_dbm),
        .analysis_enabled      (analysis_enabled),
        .window_ms             (window_reg),
        .caution_count         (caut_cnt_reg),
        .alert_count           (alert_cnt_reg),
        .broadcast_count_limit (bcast_cnt_reg),
        .score_ceiling         (ceil_reg),
        .caution_score         (caut_sc_reg),
        .alert_score           (alert_sc_reg),
        .decay_interval_ms     (decay_reg),
        .done                  (done),
        .score                 (score),
        .level                 (level),
        .frame_status          (frame_status),
        .points_raised         (points_raised)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held two cycles");
endmodule

// ===== hdl/dbts_ram.sv =====
// Generic single-port RAM with registered read.
module dbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/dbts_ctrl.sv =====
// Controller state machine for the scorer.
module dbts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dbts_pkg::dbts_stat_t stat,
    output dbts_pkg::dbts_cmd_t  cmd,
    output logic                 busy
);
    import dbts_pkg::*;

    cstate_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != CS_IDLE);
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    // decoded opcode is registered; branch in the next cycle
                    state_next = CS_FSEARCH;
                end
            end
            CS_FSEARCH:
            begin
                // the first cycle after load routes by opcode
                priority if (stat.op == OP_TICK)
                begin
                    // RAM read of slot 0 issued now; index advances each cycle
                    cmd.scan_inc = 1'b1;
                    state_next = stat.scan_last ? CS_TLAST : CS_TWALK;
                end
                else if (stat.op != OP_FRAME || stat.filtered)
                begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
                else
                begin
                    if (stat.cur_match) cmd.hit_take = 1'b1;
                    if (stat.cur_free) cmd.free_take = 1'b1;
                    if (stat.cur_match || stat.scan_last)
                    begin
                        state_next = CS_FALLOC;
                    end
                    else
                    begin
                        cmd.scan_inc = 1'b1;
                    end
                end
            end
            CS_FALLOC:
            begin
                priority if (stat.have_hit)
                begin
                    state_next = CS_FREAD;
                end
                else if (stat.have_free)
                begin
                    cmd.alloc = 1'b1;
                    state_next = CS_FREAD;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            CS_FREAD:
            begin
                cmd.rd_hit = 1'b1;
                state_next = CS_FWAIT;
            end
            CS_FWAIT:
            begin
                state_next = CS_FWRITE;
            end
            CS_FWRITE:
            begin
                cmd.wr_hit = 1'b1;
                cmd.finish = 1'b1;
                state_next = CS_IDLE;
            end
            CS_TWALK:
            begin
                cmd.tick_acc = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = CS_TLAST;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            CS_TLAST:
            begin
                // score the last slot, whose read was issued in the final walk cycle
                cmd.tick_acc = 1'b1;
                state_next = CS_TFINISH;
            end
            CS_TFINISH:
            begin
                cmd.tick_fin = 1'b1;
                state_next = CS_DONE;
            end
            CS_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.alloc && cmd.wr_hit)) else $error("alloc and write-back together");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == CS_IDLE) else $error("finish not followed by idle");
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_fin |=> cmd.finish) else $error("tick finish without result");
endmodule

// ===== hdl/dbts_dp.sv =====
// Datapath: slot table, search index, scoring and result registers.
module dbts_dp #(
    parameter int SOURCE_SLOTS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dbts_pkg::dbts_cmd_t  cmd,
    output dbts_pkg::dbts_stat_t stat,
    input  logic [1:0]           opcode,
    input  logic [31:0]          time_ms,
    input  logic [47:0]          source_mac,
    input  logic [47:0]          dest_mac,
    input  logic [7:0]           frame_control_low,
    input  logic signed [7:0]    signal_dbm,
    input  logic                 analysis_enabled,
    input  logic [31:0]          window_ms,
    input  logic [15:0]          caution_count,
    input  logic [15:0]          alert_count,
    input  logic [15:0]          broadcast_count_limit,
    input  logic [4:0]           score_ceiling,
    input  logic [4:0]           caution_score,
    input  logic [4:0]           alert_score,
    input  logic [31:0]          decay_interval_ms,
    output logic                 done,
    output logic [4:0]           score,
    output logic [1:0]           level,
    output logic [1:0]           frame_status,
    output logic [7:0]           points_raised
);
    import dbts_pkg::*;

    localparam int IW = $clog2(SOURCE_SLOTS > 1 ? SOURCE_SLOTS : 2);
    localparam int DW = 48 + 2 * COUNT_BITS + 32;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // captured item
    opcode_t          op_reg;
    logic [31:0]      now_reg;
    logic [47:0]      src_reg;
    logic             bcast_reg;
    logic             filt_reg;
    logic             en_reg;

    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    hit_idx_reg, free_idx_reg;
    logic             have_hit_reg, have_free_reg, new_reg;
    logic [SOURCE_SLOTS-1:0] valid_reg;
    logic             tick_v_reg;   // RAM output holds a slot being walked
    logic [IW-1:0]    tick_i_reg;

    logic [4:0]       score_reg;
    logic [1:0]       level_reg;
    logic [31:0]      last_decay_reg;
    logic [7:0]       raised_reg;
    logic [1:0]       status_reg;
    logic             done_reg;

    logic             ram_we;
    logic [IW-1:0]    ram_addr;
    logic [DW-1:0]    ram_wdata, ram_rdata;

    logic [47:0]           r_src;
    logic [COUNT_BITS-1:0] r_fc, r_bc;
    logic [31:0]           r_ws;

    assign {r_src, r_fc, r_bc, r_ws} = ram_rdata;

    logic sig_ok, type_ok, sub_ok;
    assign sig_ok  = signal_dbm >= SIGNAL_FLOOR;
    assign type_ok = frame_control_low[3:2] == 2'b00;
    assign sub_ok  = frame_control_low[7:4] == SUB_DISASSOC
                  || frame_control_low[7:4] == SUB_DEAUTH;

    // frame search compares against the register copy of sources
    logic [47:0] src_tab [SOURCE_SLOTS];
    logic        cur_match;
    assign cur_match = valid_reg[idx_reg] && src_tab[idx_reg] == src_reg;

    assign stat.filtered  = filt_reg;
    assign stat.scan_last = idx_reg == IW'(SOURCE_SLOTS - 1);
    assign stat.cur_match = cur_match;
    assign stat.cur_free  = !valid_reg[idx_reg] && !have_free_reg;
    assign stat.have_hit  = have_hit_reg;
    assign stat.have_free = have_free_reg;
    assign stat.op        = op_reg;

    logic [IW-1:0] sel_idx;
    assign sel_idx = have_hit_reg ? hit_idx_reg : free_idx_reg;

    // window roll and count update for the selected slot
    logic                  roll;
    logic [COUNT_BITS-1:0] fc_base, bc_base;
    logic [31:0]           ws_new;
    assign roll    = new_reg || ((now_reg - r_ws) > window_ms);
    assign fc_base = roll ? '0 : r_fc;
    assign bc_base = roll ? '0 : r_bc;
    assign ws_new  = roll ? now_reg : r_ws;

    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = idx_reg;
        ram_wdata = {src_reg, fc_base == CMAX ? CMAX : fc_base + 1'b1,
                     (bcast_reg && bc_base != CMAX) ? bc_base + 1'b1 : bc_base, ws_new};
        if (cmd.rd_hit)
        begin
            ram_addr = sel_idx;
        end
        if (cmd.wr_hit)
        begin
            ram_addr = sel_idx;
            ram_we = 1'b1;
        end
    end

    dbts_ram #(.WIDTH(DW), .DEPTH(SOURCE_SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // tick scoring of one slot
    logic [2:0] pts;
    logic       live;
    assign live = tick_v_reg && valid_reg[tick_i_reg] && ((now_reg - r_ws) <= window_ms);
    always_comb
    begin
        pts = 3'd0;
        if (live && en_reg)
        begin
            if ({{(32-COUNT_BITS){1'b0}}, r_fc} >= {16'd0, alert_count}) pts = 3'd4;
            else if ({{(32-COUNT_BITS){1'b0}}, r_fc} >= {16'd0, caution_count}) pts = 3'd2;
            if ({{(32-COUNT_BITS){1'b0}}, r_bc} >= {16'd0, broadcast_count_limit})
                pts = pts + 3'd1;
        end
    end

    logic [5:0] sc_sum;
    logic [8:0] rs_sum;
    assign sc_sum = {1'b0, score_reg} + {3'd0, pts};
    assign rs_sum = {1'b0, raised_reg} + {6'd0, pts};

    logic [4:0] sc_dec;
    assign sc_dec = ((now_reg - last_decay_reg) >= decay_interval_ms && score_reg != 5'd0)
                  ? score_reg - 5'd1 : score_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            src_tab[free_idx_reg] <= src_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            score_reg <= '0;
            level_reg <= LV_STARTUP;
            last_decay_reg <= '0;
            done_reg <= 1'b0;
            tick_v_reg <= 1'b0;
            op_reg <= OP_NONE;
            filt_reg <= 1'b0;
            idx_reg <= '0;
            have_hit_reg <= 1'b0;
            have_free_reg <= 1'b0;
            new_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            // every tick cycle that walks or scores issues a read of the indexed slot
            tick_v_reg <= (op_reg == OP_TICK) && (cmd.scan_inc || cmd.tick_acc);
            tick_i_reg <= idx_reg;
            if (cmd.load)
            begin
                op_reg <= opcode_t'(opcode);
                now_reg <= time_ms;
                src_reg <= source_mac;
                bcast_reg <= dest_mac == 48'hFFFF_FFFF_FFFF;
                filt_reg <= !(sig_ok && type_ok && sub_ok);
                en_reg <= analysis_enabled;
                have_hit_reg <= 1'b0;
                have_free_reg <= 1'b0;
                new_reg <= 1'b0;
                raised_reg <= '0;
                status_reg <= ST_NOFRAME;
                if (opcode_t'(opcode) == OP_CLEAR)
                begin
                    score_reg <= '0;
                end
            end
            if (cmd.scan_clr) idx_reg <= '0;
            else if (cmd.scan_inc) idx_reg <= idx_reg + 1'b1;
            if (cmd.hit_take)
            begin
                have_hit_reg <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if (cmd.free_take)
            begin
                have_free_reg <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if (cmd.alloc)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                new_reg <= 1'b1;
            end
            if (cmd.finish && op_reg == OP_FRAME)
            begin
                status_reg <= filt_reg ? ST_FILTERED
                            : (have_hit_reg || have_free_reg) ? ST_COUNTED : ST_FULL;
            end
            if (cmd.tick_acc && pts != 3'd0)
            begin
                score_reg <= (sc_sum > {1'b0, score_ceiling}) ? score_ceiling : sc_sum[4:0];
                raised_reg <= rs_sum[8] ? 8'hFF : rs_sum[7:0];
            end
            if (cmd.tick_fin)
            begin
                score_reg <= sc_dec;
                if ((now_reg - last_decay_reg) >= decay_interval_ms)
                    last_decay_reg <= now_reg;
                priority if (!en_reg) level_reg <= LV_STARTUP;
                else if (sc_dec >= alert_score) level_reg <= LV_ALERT;
                else if (sc_dec >= caution_score) level_reg <= LV_CAUTION;
                else level_reg <= LV_NORMAL;
            end
        end
    end

    assign done          = done_reg;
    assign score         = score_reg;
    assign level         = level_reg;
    assign frame_status  = status_reg;
    assign points_raised = raised_reg;

    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> !valid_reg[free_idx_reg]) else $error("alloc over a valid slot");
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_hit |-> valid_reg[sel_idx]) else $error("write-back to an invalid slot");
    a_score_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_acc && pts != 3'd0) |=> score_reg <= $past(score_ceiling))
        else $error("score above ceiling");
endmodule

// ===== sim/dbts_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the deauth burst threat scorer: predicts and compares.
module dbts_checker #(
    parameter int SLOTS = 32,
    parameter int CNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              done,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [1:0]        opcode,
    input  logic [31:0]       time_ms,
    input  logic [47:0]       source_mac,
    input  logic [47:0]       dest_mac,
    input  logic [7:0]        frame_control_low,
    input  logic signed [7:0] signal_dbm,
    input  logic              analysis_enabled,
    input  logic [4:0]        score,
    input  logic [1:0]        level,
    input  logic [1:0]        frame_status,
    input  logic [7:0]        points_raised,
    output int                fail_count,
    output int                pending
);
    import dbts_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [4:0] score;
        logic [1:0] level;
        logic [1:0] status;
        logic [7:0] points;
    } verdict_t;

    verdict_t verdict_q[$];

    logic [31:0] r_window, r_decay;
    logic [15:0] r_caut_cnt, r_alert_cnt, r_bcast_cnt;
    logic [4:0]  r_ceiling, r_caut_sc, r_alert_sc;

    logic                tbl_valid [SLOTS];
    logic [47:0]         tbl_src   [SLOTS];
    logic [CNT_BITS-1:0] tbl_cnt   [SLOTS];
    logic [CNT_BITS-1:0] tbl_bcnt  [SLOTS];
    logic [31:0]         tbl_start [SLOTS];
    int unsigned         cur_score;
    logic [31:0]         last_decay;
    level_t              cur_level;

    function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    task automatic add_pts(input int unsigned pts, inout int unsigned raised);
        if (pts != 0)
        begin
            cur_score += pts;
            if (cur_score > r_ceiling)
                cur_score = r_ceiling;
            raised += pts;
            if (raised > 255)
                raised = 255;
        end
    endtask

    task automatic count_frame(output fstatus_t st);
        int hit;
        logic [3:0] sub;
        hit = -1;
        sub = frame_control_low[7:4];
        st = ST_COUNTED;
        if (signal_dbm < SIGNAL_FLOOR || frame_control_low[3:2] != 2'd0
            || (sub != SUB_DISASSOC && sub != SUB_DEAUTH))
        begin
            st = ST_FILTERED;
            return;
        end
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_valid[i] && tbl_src[i] == source_mac)
                hit = i;
        if (hit < 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && !tbl_valid[i])
                begin
                    hit = i;
                    tbl_valid[i] = 1'b1;
                    tbl_src[i] = source_mac;
                    tbl_cnt[i] = '0;
                    tbl_bcnt[i] = '0;
                    tbl_start[i] = time_ms;
                end
        end
        if (hit < 0)
        begin
            st = ST_FULL;
            return;
        end
        if (32'(time_ms - tbl_start[hit]) > r_window)
        begin
            tbl_cnt[hit] = '0;
            tbl_bcnt[hit] = '0;
            tbl_start[hit] = time_ms;
        end
        tbl_cnt[hit] = bump(tbl_cnt[hit]);
        if (&dest_mac)
            tbl_bcnt[hit] = bump(tbl_bcnt[hit]);
    endtask

    task automatic score_tick(output int unsigned raised);
        raised = 0;
        if (analysis_enabled)
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!tbl_valid[i] || 32'(time_ms - tbl_start[i]) > r_window)
                    continue;
                if (tbl_cnt[i] >= r_alert_cnt)
                    add_pts(4, raised);
                else if (tbl_cnt[i] >= r_caut_cnt)
                    add_pts(2, raised);
                if (tbl_bcnt[i] >= r_bcast_cnt)
                    add_pts(1, raised);
            end
        if (32'(time_ms - last_decay) >= r_decay)
        begin
            last_decay = time_ms;
            if (cur_score > 0)
                cur_score--;
        end
        if (!analysis_enabled)
            cur_level = LV_STARTUP;
        else if (cur_score >= r_alert_sc)
            cur_level = LV_ALERT;
        else if (cur_score >= r_caut_sc)
            cur_level = LV_CAUTION;
        else
            cur_level = LV_NORMAL;
    endtask

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        fstatus_t st;
        int unsigned raised;
        verdict_t v, got;
        if (!rst_n)
        begin
            r_window = 32'd5000;    r_caut_cnt = 16'd8;  r_alert_cnt = 16'd20;
            r_bcast_cnt = 16'd5;    r_ceiling = 5'd20;   r_caut_sc = 5'd3;
            r_alert_sc = 5'd6;      r_decay = 32'd60000;
            for (int i = 0; i < SLOTS; i++)
                tbl_valid[i] = 1'b0;
            cur_score = 0;
            last_decay = '0;
            cur_level = LV_STARTUP;
            verdict_q.delete();
            fail_count = 0;
        end
        else
        begin
            // Check the result first: it belongs to an earlier transfer.
            if (done)
            begin
                got = '{score, level, frame_status, points_raised};
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected result");
                    fail_count++;
                end
                else
                begin
                    v = verdict_q.pop_front();
                    if (got.score !== v.score)
                    begin
                        $error("score exp %0d got %0d", v.score, got.score);
                        fail_count++;
                    end
                    if (got.level !== v.level)
                    begin
                        $error("level exp %0d got %0d", v.level, got.level);
                        fail_count++;
                    end
                    if (got.status !== v.status)
                    begin
                        $error("frame_status exp %0d got %0d", v.status, got.status);
                        fail_count++;
                    end
                    if (got.points !== v.points)
                    begin
                        $error("points_raised exp %0d got %0d", v.points, got.points);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                case (cfg_index)
                    REG_WINDOW:    r_window = cfg_data;
                    REG_CAUT_CNT:  r_caut_cnt = cfg_data[15:0];
                    REG_ALERT_CNT: r_alert_cnt = cfg_data[15:0];
                    REG_BCAST_CNT: r_bcast_cnt = cfg_data[15:0];
                    REG_CEILING:   r_ceiling = cfg_data[4:0];
                    REG_CAUT_SC:   r_caut_sc = cfg_data[4:0];
                    REG_ALERT_SC:  r_alert_sc = cfg_data[4:0];
                    default:       r_decay = cfg_data;
                endcase
            if (start && !busy)
            begin
                st = ST_NOFRAME;
                raised = 0;
                case (opcode_t'(opcode))
                    OP_FRAME: count_frame(st);
                    OP_TICK:  score_tick(raised);
                    OP_CLEAR: cur_score = 0;
                    default:  ;
                endcase
                v = '{5'(cur_score), cur_level, st, 8'(raised)};
                verdict_q.push_back(v);
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: stimulus, configuration phases and the verdict.
module tb_top;
    import dbts_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;
    logic [1:0]        opcode;
    logic [31:0]       time_ms;
    logic [47:0]       source_mac;
    logic [47:0]       dest_mac;
    logic [7:0]        frame_control_low;
    logic signed [7:0] signal_dbm;
    logic              analysis_enabled;
    logic [4:0]        score;
    logic [1:0]        level;
    logic [1:0]        frame_status;
    logic [7:0]        points_raised;
    int                fail_count;
    int                pending;

    // Percent of cycles the sender leaves start low between transfers.
    int                gap_pct;
    // Simulated clock; advances up to 300 ms per item, with a rare large jump, so windows open and roll.
    logic [31:0]       now_ms;
    // Small pool of source addresses so the table both hits and fills up.
    logic [47:0]       mac_pool [48];

    deauth_burst_threat_scorer_top u_dut (.*);

    dbts_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold start until the block takes the transfer; lower it after.
    task automatic send_item(input opcode_t op, input logic [31:0] t,
                             input logic [47:0] src, input logic [47:0] dst,
                             input logic [7:0] fc, input logic [7:0] sig,
                             input logic en);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct)
            @(negedge clk);
        opcode = op;
        time_ms = t;
        source_mac = src;
        dest_mac = dst;
        frame_control_low = fc;
        signal_dbm = sig;
        analysis_enabled = en;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Write a register; only called with the block idle and nothing pending.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drain every expected result, then let the block settle before config.
    task automatic drain;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // Mostly well-formed management frames with random content, some noise, plus ticks, clears and unused ops.
    task automatic random_item;
        int r;
        logic [7:0] fc;
        logic [7:0] sig;
        logic [47:0] dst;
        r = $urandom_range(99);
        now_ms += $urandom_range(300);
        if ($urandom_range(199) == 0)
            now_ms += $urandom;
        fc = {($urandom_range(1) ? SUB_DEAUTH : SUB_DISASSOC), 2'b00, 2'($urandom)};
        if ($urandom_range(9) == 0)
            fc = 8'($urandom);
        sig = 8'($urandom_range(160) - 94);
        if ($urandom_range(9) == 0)
            sig = 8'($urandom);
        dst = $urandom_range(1) ? '1 : {16'($urandom), 32'($urandom)};
        if (r < 72)
            send_item(OP_FRAME, now_ms, mac_pool[$urandom_range(47)], dst, fc, sig,
                      1'($urandom));
        else if (r < 92)
            send_item(OP_TICK, now_ms, {16'($urandom), 32'($urandom)}, dst, fc, sig,
                      $urandom_range(7) != 0);
        else if (r < 97)
            send_item(OP_CLEAR, now_ms, 48'($urandom), dst, fc, sig, 1'($urandom));
        else
            send_item(OP_NONE, now_ms, 48'($urandom), dst, fc, sig, 1'($urandom));
    endtask

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WINDOW;
        cfg_data = '0;
        opcode = OP_FRAME;
        time_ms = '0;
        source_mac = '0;
        dest_mac = '0;
        frame_control_low = '0;
        signal_dbm = '0;
        analysis_enabled = 1'b0;
        gap_pct = 0;
        now_ms = 32'd1000;
        for (int i = 0; i < 48; i++)
            mac_pool[i] = {16'($urandom), 32'($urandom)};
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: filters, broadcast, ticks enabled and not, clear, unused op.
        send_item(OP_TICK, 32'd0, '0, '0, '0, '0, 1'b0);
        send_item(OP_FRAME, 32'd10, mac_pool[0], '1, 8'hC0, 8'hA1, 1'b0);  // -95
        send_item(OP_FRAME, 32'd11, mac_pool[0], '1, 8'hC0, 8'hA0, 1'b0);  // -96
        send_item(OP_FRAME, 32'd12, mac_pool[0], '1, 8'hC4, 8'h7F, 1'b0);  // bad type
        send_item(OP_FRAME, 32'd13, mac_pool[0], '1, 8'hB0, 8'h80, 1'b0);  // bad subtype
        send_item(OP_FRAME, 32'd14, mac_pool[1], '1, 8'hA3, 8'h00, 1'b1);
        send_item(OP_FRAME, 32'd15, mac_pool[1], '0, 8'hFF, 8'h00, 1'b1);
        for (int i = 0; i < 8; i++)
            send_item(OP_FRAME, 32'd20 + i, mac_pool[1], '1, 8'hC0, 8'h10, 1'b1);
        send_item(OP_TICK, 32'd100, '1, '1, '1, '1, 1'b1);
        send_item(OP_TICK, 32'd200, '0, '0, '0, '0, 1'b0);
        send_item(OP_FRAME, 32'd9000, mac_pool[1], '1, 8'hC0, 8'h10, 1'b1); // roll
        send_item(OP_CLEAR, 32'd9001, '1, '1, '1, '1, 1'b1);
        send_item(OP_NONE, 32'hFFFF_FFFF, '1, '1, '1, '1, 1'b1);
        drain();

        // Fill the table past its size to hit the full case.
        for (int i = 0; i < 34; i++)
            send_item(OP_FRAME, 32'd9100, mac_pool[i + 2], '1, 8'hA0, 8'h00, 1'b1);
        send_item(OP_TICK, 32'd9200, '0, '0, '0, '0, 1'b1);
        drain();

        // Random phases with varied settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            gap_pct = (ph < 3) ? 27 : (ph < 5 ? 86 : 0);
            case (ph)
                0:
                begin
                    write_reg(REG_WINDOW, 32'd1);
                    write_reg(REG_CAUT_CNT, 32'd1);
                    write_reg(REG_ALERT_CNT, 32'd1);
                    write_reg(REG_BCAST_CNT, 32'd1);
                    write_reg(REG_CEILING, 32'd31);
                    write_reg(REG_CAUT_SC, 32'd0);
                    write_reg(REG_ALERT_SC, 32'd31);
                    write_reg(REG_DECAY, 32'd1);
                end
                1:
                begin
                    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
                    write_reg(REG_CAUT_CNT, 32'hFFFF);
                    write_reg(REG_ALERT_CNT, 32'hFFFF);
                    write_reg(REG_BCAST_CNT, 32'hFFFF);
                    write_reg(REG_CEILING, 32'd1);
                    write_reg(REG_CAUT_SC, 32'd31);
                    write_reg(REG_ALERT_SC, 32'd0);
                    write_reg(REG_DECAY, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_reg(REG_WINDOW, $urandom_range(8000, 200));
                    write_reg(REG_CAUT_CNT, $urandom_range(12));
                    write_reg(REG_ALERT_CNT, $urandom_range(30));
                    write_reg(REG_BCAST_CNT, $urandom_range(8));
                    write_reg(REG_CEILING, $urandom);
                    write_reg(REG_CAUT_SC, $urandom_range(10));
                    write_reg(REG_ALERT_SC, $urandom_range(31));
                    write_reg(REG_DECAY, $urandom_range(5000));
                end
            endcase
            for (int n = 0; n < 190; n++)
                random_item();
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dbts_pkg.sv
hdl/dbts_ram.sv
hdl/dbts_ctrl.sv
hdl/dbts_dp.sv
hdl/deauth_burst_threat_scorer_top.sv
sim/dbts_checker.sv
sim/tb_top.sv
